// File: hdl/preemptive_priority_scheduler_macros.svh
// Assertion macros for the preemptive priority scheduler.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define PPS_ASSERT_NEVER(lbl, cond, msg) \
  `PPS_ASSERT(lbl, !(cond), msg)

`endif

// File: hdl/pps_pkg.sv
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int DEF_MAX_TASKS = 8;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 16;
  localparam int SLOT_W = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } pps_entry_t;

  localparam int ENTRY_W = $bits(pps_entry_t);
  localparam int KEY_W   = PRIO_W + TIME_W + TIME_W + ID_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pps_state_e;

endpackage

// File: hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: task table in RAM, one slot scanned per cycle.
//
//   channel  direction  handshake                 words
//   in       input      in_valid_i / in_stall_o   load or tick command
//   out      output     out_valid_o / out_stall_i one result per tick
//
// A load is written in ST_IDLE; a tick accepted in ST_IDLE starts the read
// of slot 0, ST_SCAN then reads and compares one table slot at a time from the
// RAM port, and ST_FINISH writes back the winner and loads the result.
// The table RAM needs no clearing; per-slot valid and active flags clear on reset.
// A pending result blocks only the final cycle of the next tick; loads pass by.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  logic [PRIO_W-1:0] priority_req_i,
  input  logic [TIME_W-1:0] arrival_i,
  input  logic [TIME_W-1:0] burst_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TIME_W-1:0] tick_time_o,
  output logic [ID_W-1:0]   granted_id_o,
  output logic              idle_o,
  output logic              task_finished_o,
  output logic              all_done_o
);

  `include "preemptive_priority_scheduler_macros.svh"

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  pps_state_e state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     win_q, win_d;
  logic                 found_q, found_d;
  pps_entry_t           best_q, best_d;
  logic [MAX_TASKS-1:0] valid_q, valid_d;
  logic [MAX_TASKS-1:0] active_q, active_d;
  logic [TIME_W-1:0]    current_time_q, current_time_d;

  logic              out_valid_q;
  logic [TIME_W-1:0] tick_time_q, tick_time_d;
  logic [ID_W-1:0]   granted_id_q, granted_id_d;
  logic              idle_q, idle_d;
  logic              task_finished_q, task_finished_d;
  logic              all_done_q, all_done_d;
  logic              out_load;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  pps_entry_t       wr_entry;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  pps_entry_t       rd_entry;

  logic             in_accept;
  logic             out_free;
  logic             slot_in_range;
  logic [IDX_W-1:0] slot_idx;
  logic             eligible;
  logic             better;
  logic [KEY_W-1:0] rd_key;
  logic [KEY_W-1:0] best_key;
  logic [TIME_W-1:0] new_rem;

  pps_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_TASKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_wdata = wr_entry;
  assign rd_entry  = pps_entry_t'(ram_rdata);

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign slot_in_range = (32'(slot_i) < MAX_TASKS);
  assign slot_idx      = IDX_W'(slot_i);

  assign rd_key   = {rd_entry.prio, rd_entry.arrival, rd_entry.burst, rd_entry.id};
  assign best_key = {best_q.prio, best_q.arrival, best_q.burst, best_q.id};
  assign eligible = active_q[cnt_q] && (rd_entry.arrival <= current_time_q);
  assign better   = !found_q || (rd_key < best_key);
  assign new_rem  = best_q.remaining - TIME_W'(1);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    win_d           = win_q;
    found_d         = found_q;
    best_d          = best_q;
    valid_d         = valid_q;
    active_d        = active_q;
    current_time_d  = current_time_q;
    tick_time_d     = tick_time_q;
    granted_id_d    = granted_id_q;
    idle_d          = idle_q;
    task_finished_d = task_finished_q;
    all_done_d      = all_done_q;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_raddr       = '0;
    wr_entry        = best_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd_i == CMD_LOAD) begin
            if (slot_in_range) begin
              ram_we             = 1'b1;
              ram_waddr          = slot_idx;
              wr_entry.id        = task_id_i;
              wr_entry.prio      = priority_req_i;
              wr_entry.arrival   = arrival_i;
              wr_entry.burst     = burst_i;
              wr_entry.remaining = burst_i;
              valid_d[slot_idx]  = 1'b1;
              active_d[slot_idx] = (burst_i != '0);
            end
          end else begin
            ram_raddr = '0;
            cnt_d     = '0;
            found_d   = 1'b0;
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = cnt_q + IDX_W'(1);
        if (eligible && better) begin
          best_d  = rd_entry;
          win_d   = cnt_q;
          found_d = 1'b1;
        end
        if (cnt_q == LAST_IDX) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          if (found_q) begin
            ram_we             = 1'b1;
            ram_waddr          = win_q;
            wr_entry.remaining = new_rem;
            if (new_rem == '0) begin
              active_d[win_q] = 1'b0;
            end
          end
          out_load        = 1'b1;
          tick_time_d     = current_time_q;
          granted_id_d    = found_q ? best_q.id : '0;
          idle_d          = !found_q;
          task_finished_d = found_q && (new_rem == '0);
          all_done_d      = ~|active_d;
          current_time_d  = current_time_q + TIME_W'(1);
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      found_q        <= 1'b0;
      valid_q        <= '0;
      active_q       <= '0;
      current_time_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      found_q        <= found_d;
      valid_q        <= valid_d;
      active_q       <= active_d;
      current_time_q <= current_time_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q           <= win_d;
    best_q          <= best_d;
    tick_time_q     <= tick_time_d;
    granted_id_q    <= granted_id_d;
    idle_q          <= idle_d;
    task_finished_q <= task_finished_d;
    all_done_q      <= all_done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign tick_time_o     = tick_time_q;
  assign granted_id_o    = granted_id_q;
  assign idle_o          = idle_q;
  assign task_finished_o = task_finished_q;
  assign all_done_o      = all_done_q;

  `PPS_ASSERT(a_tick_starts_scan, (in_accept && cmd_i == CMD_TICK) |=> (state_q == ST_SCAN), "tick did not start a scan")
  `PPS_ASSERT_NEVER(a_active_is_valid, (active_q & ~valid_q) != '0, "active flag on an empty slot")
  `PPS_ASSERT(a_time_advance, out_load |=> (current_time_q == TIME_W'($past(current_time_q) + 1)), "time did not advance with a result")
  `PPS_ASSERT_NEVER(a_idle_not_finished, out_valid_o && idle_o && task_finished_o, "idle tick reports a finished task")

endmodule

// File: hdl/pps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
